// ----- sv/hsla_pkg.sv -----
// ----------------------------------------------------------------------------
// HSL lightness adjust - shared package
// Widths, reset values, register map and sideband types for the block.
// ----------------------------------------------------------------------------
package hsla_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int CH_W          = 8;
    localparam int DELTA_W       = 14;
    localparam int DIV_W         = 9;    // channel sums and spans, max 510
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic signed [DELTA_W-1:0] DELTA_RST = 14'sd410;

    // register index, taken from paddr[2]
    localparam logic REG_LIGHTNESS_DELTA = 1'b0;

    // which channel is the largest, sets the hue base
    typedef enum logic [1:0] {
        BASE_RED   = 2'b00,
        BASE_GREEN = 2'b01,
        BASE_BLUE  = 2'b10
    } t_base;

    // per-pixel control travelling alongside the dividers
    typedef struct packed {
        logic              mask;
        logic [CH_W-1:0]   alpha;
        t_base             base;
        logic              num_neg;
        logic              d_zero;
    } t_side;

endpackage

// ----- sv/hsla_if.sv -----
// ----------------------------------------------------------------------------
// HSL lightness adjust - stream interfaces
// Pixel input channel and adjusted pixel output channel, valid/ready.
// ----------------------------------------------------------------------------
interface hsla_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       mask_on;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, mask_on,
                    input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, mask_on,
                    output ready);
endinterface

interface hsla_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                    output ready);
endinterface

// ----- sv/hsl_lightness_adjust_unit.sv -----
// ----------------------------------------------------------------------------
// HSL lightness adjust unit - top level
// RGB to HSL, signed lightness offset, HSL back to RGB, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix : pixel stream in (RGBA + mask_on), a transfer when valid && ready.
//   o_res : adjusted RGBA out, same handshake. One result per input pixel.
//   APB   : register 0 at byte address 0 holds the 14-bit signed lightness
//           offset (4096 = 1.0); write it only while the pipeline is empty.
// Throughput: one pixel per clock while the output is not stalled. Stages:
//   one input stage, FRAC_BITS + 1 stages of the bit-per-stage fraction
//   dividers (saturation, hue), and seven back-end stages with the two
//   chroma multipliers. Lightness divides by the constant 510: the channel
//   sum rides alongside the dividers and the quotient is wired from the
//   repeating 8-bit pattern of sum mod 255.
// Stall: the whole pipe advances on one enable, high when the output
//   register is empty or being taken. With a result waiting and o_res.ready
//   low the pipe holds, i_pix.ready drops, and nothing is lost or repeated.
// Reset: synchronous, active low. All stage valid bits clear, the offset
//   returns to 410 (about 0.1). No clearing pass is needed.
// A pixel with mask_on low leaves as transparent black (0,0,0,0).
// ----------------------------------------------------------------------------
module hsl_lightness_adjust_unit #(
    parameter int FRAC_BITS = hsla_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hsla_pix_if.sink                        i_pix,
    hsla_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsla_pkg::APB_AW-1:0]     paddr,
    input  logic [hsla_pkg::APB_DW-1:0]     pwdata,
    output logic [hsla_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    localparam int W = hsla_pkg::DIV_W;

    logic                                 en;
    logic                                 back_vld;
    logic signed [hsla_pkg::DELTA_W-1:0]  delta;

    // global advance: output empty or being drained
    assign en          = !back_vld || o_res.ready;
    assign i_pix.ready = en;

    hsla_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_delta (delta)
    );

    // ---- input stage: max/min, divider operands
    logic [7:0]      mx, mn, na, nb, absn;
    logic [W-1:0]    sum;
    hsla_pkg::t_side n_side;

    logic            r_a_vld;
    logic [W-1:0]    r_a_sum, r_a_sden, r_a_d, r_a_absn;
    hsla_pkg::t_side r_a_side;

    always_comb begin
        mx = (i_pix.red_in > i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in > mx) begin
            mx = i_pix.blue_in;
        end
        mn = (i_pix.red_in < i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in < mn) begin
            mn = i_pix.blue_in;
        end
        sum = W'(mx) + W'(mn);

        // red tested first, then green, then blue
        if (mx == i_pix.red_in) begin
            n_side.base = hsla_pkg::BASE_RED;
            na = i_pix.green_in;
            nb = i_pix.blue_in;
        end else if (mx == i_pix.green_in) begin
            n_side.base = hsla_pkg::BASE_GREEN;
            na = i_pix.blue_in;
            nb = i_pix.red_in;
        end else begin
            n_side.base = hsla_pkg::BASE_BLUE;
            na = i_pix.red_in;
            nb = i_pix.green_in;
        end
        n_side.num_neg = (na < nb);
        absn           = n_side.num_neg ? nb - na : na - nb;
        n_side.d_zero  = (mx == mn);
        n_side.mask    = i_pix.mask_on;
        n_side.alpha   = i_pix.alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sum  <= sum;
            // 255 - |sum - 255|
            r_a_sden <= (sum <= W'(255)) ? sum : W'(510) - sum;
            r_a_d    <= W'(mx - mn);
            r_a_absn <= W'(absn);
            r_a_side <= n_side;
        end
    end

    // ---- fraction dividers
    logic [FRAC_BITS:0] lum, sat, mag;

    hsla_div #(.FRAC_BITS(FRAC_BITS)) u_div_sat (
        .i_clk (i_clk), .i_en (en),
        .i_num (r_a_d), .i_den (r_a_sden), .o_quo (sat)
    );

    hsla_div #(.FRAC_BITS(FRAC_BITS)) u_div_hue (
        .i_clk (i_clk), .i_en (en),
        .i_num (r_a_absn), .i_den (r_a_d), .o_quo (mag)
    );

    // sideband and channel sum keep step with the dividers
    logic            r_sd_vld  [0:FRAC_BITS];
    hsla_pkg::t_side r_sd_side [0:FRAC_BITS];
    logic [W-1:0]    r_sd_sum  [0:FRAC_BITS];

    for (genvar s = 0; s <= FRAC_BITS; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd_vld[s] <= 1'b0;
            end else if (en) begin
                r_sd_vld[s] <= (s == 0) ? r_a_vld : r_sd_vld[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd_side[s] <= (s == 0) ? r_a_side : r_sd_side[(s == 0) ? 0 : s-1];
                r_sd_sum[s]  <= (s == 0) ? r_a_sum : r_sd_sum[(s == 0) ? 0 : s-1];
            end
        end
    end

    // ---- lightness: floor(sum * 2^(F-1) / 255)
    // sum = 255k + rr; rr / 255 in binary is the 8 bits of rr repeated
    logic [W-1:0] lum_sum;
    logic [1:0]   lum_k;
    logic [7:0]   lum_rr;

    assign lum_sum = r_sd_sum[FRAC_BITS];

    always_comb begin
        if (lum_sum >= W'(510)) begin
            lum_k  = 2'd2;
            lum_rr = 8'd0;
        end else if (lum_sum >= W'(255)) begin
            lum_k  = 2'd1;
            lum_rr = 8'(lum_sum - W'(255));
        end else begin
            lum_k  = 2'd0;
            lum_rr = lum_sum[7:0];
        end
    end

    assign lum[FRAC_BITS:FRAC_BITS-1] = lum_k;
    for (genvar i = 0; i < FRAC_BITS - 1; i++) begin : g_lum
        assign lum[FRAC_BITS-2-i] = lum_rr[7 - (i % 8)];
    end

    // ---- back conversion
    hsla_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sd_vld[FRAC_BITS]),
        .i_lum   (lum),
        .i_sat   (sat),
        .i_mag   (mag),
        .i_side  (r_sd_side[FRAC_BITS]),
        .i_delta (delta),
        .o_valid (back_vld),
        .o_red   (o_res.red_out),
        .o_green (o_res.green_out),
        .o_blue  (o_res.blue_out),
        .o_alpha (o_res.alpha_out)
    );

    assign o_res.valid = back_vld;
endmodule

// ----- sv/hsla_regs.sv -----
// ----------------------------------------------------------------------------
// HSL lightness adjust - configuration registers
// APB-style write/read of the signed lightness offset.
// ----------------------------------------------------------------------------
module hsla_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [hsla_pkg::APB_AW-1:0]            paddr,
    input  logic [hsla_pkg::APB_DW-1:0]            pwdata,
    output logic [hsla_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready,
    output logic signed [hsla_pkg::DELTA_W-1:0]    o_delta
);
    logic signed [hsla_pkg::DELTA_W-1:0] r_delta;
    logic                                w_sel;

    assign w_sel = (paddr[2] == hsla_pkg::REG_LIGHTNESS_DELTA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= hsla_pkg::DELTA_RST;
        end else if (psel && penable && pwrite && pready && w_sel) begin
            r_delta <= $signed(pwdata[hsla_pkg::DELTA_W-1:0]);
        end
    end

    assign pready  = 1'b1;
    assign prdata  = w_sel ? hsla_pkg::APB_DW'(r_delta) : '0;
    assign o_delta = r_delta;
endmodule

// ----- sv/hsla_div.sv -----
// ----------------------------------------------------------------------------
// HSL lightness adjust - pipelined fraction divider
// floor(num * 2^FRAC_BITS / den) for num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hsla_div #(
    parameter int FRAC_BITS = hsla_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [hsla_pkg::DIV_W-1:0]  i_num,
    input  logic [hsla_pkg::DIV_W-1:0]  i_den,
    output logic [FRAC_BITS:0]          o_quo
);
    localparam int W = hsla_pkg::DIV_W;

    logic [W-1:0]       r_rem [0:FRAC_BITS-1];
    logic [W-1:0]       r_den [0:FRAC_BITS-1];
    logic [FRAC_BITS:0] r_quo [0:FRAC_BITS];

    for (genvar s = 0; s <= FRAC_BITS; s++) begin : g_stage
        logic [W:0]         rin;
        logic [W-1:0]       den;
        logic [FRAC_BITS:0] qin;
        logic               bit_q;

        if (s == 0) begin : g_first
            assign rin = {1'b0, i_num};
            assign den = i_den;
            assign qin = '0;
        end else begin : g_next
            assign rin = {r_rem[s-1], 1'b0};
            assign den = r_den[s-1];
            assign qin = r_quo[s-1];
        end

        assign bit_q = (rin >= {1'b0, den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= {qin[FRAC_BITS-1:0], bit_q};
            end
        end

        // the last stage only needs its quotient bit
        if (s < FRAC_BITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= bit_q ? W'(rin - {1'b0, den}) : rin[W-1:0];
                    r_den[s] <= den;
                end
            end
        end
    end

    assign o_quo = r_quo[FRAC_BITS];
endmodule

// ----- sv/hsla_back.sv -----
// ----------------------------------------------------------------------------
// HSL lightness adjust - HSL to RGB back end
// Hue assembly, lightness offset, chroma products and channel saturation.
// ----------------------------------------------------------------------------
module hsla_back #(
    parameter int FRAC_BITS = hsla_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [FRAC_BITS:0]                   i_lum,
    input  logic [FRAC_BITS:0]                   i_sat,
    input  logic [FRAC_BITS:0]                   i_mag,
    input  hsla_pkg::t_side                      i_side,
    input  logic signed [hsla_pkg::DELTA_W-1:0]  i_delta,
    output logic                                 o_valid,
    output logic [7:0]                           o_red,
    output logic [7:0]                           o_green,
    output logic [7:0]                           o_blue,
    output logic [7:0]                           o_alpha
);
    localparam int F  = FRAC_BITS;
    localparam int LW = ((F + 2 > hsla_pkg::DELTA_W) ? F + 2 : hsla_pkg::DELTA_W) + 1;
    localparam int SW = LW + 3;
    localparam int PW = SW + F + 2;
    localparam int MW = SW + 1;
    localparam int VW = MW + 1;
    localparam int TW = VW + 8;
    localparam int HW = F + 4;

    localparam logic signed [SW-1:0] QS   = SW'(1) << F;
    localparam logic signed [HW-1:0] SIXQ = HW'(6) << F;
    localparam logic [F:0]           QU   = (F+1)'(1) << F;

    logic [6:0] r_vld;

    // stage 1
    logic [2:0]           r1_sext;
    logic [F:0]           r1_w;
    logic signed [LW-1:0] r1_lp;
    logic [F:0]           r1_sat;
    hsla_pkg::t_side      r1_side;
    // stage 2
    logic [2:0]           r2_sext;
    logic [F:0]           r2_w;
    logic signed [LW-1:0] r2_lp;
    logic [F:0]           r2_sat;
    logic signed [SW-1:0] r2_span;
    hsla_pkg::t_side      r2_side;
    // stage 3
    logic [2:0]           r3_sext;
    logic [F:0]           r3_w;
    logic signed [LW-1:0] r3_lp;
    logic signed [PW-1:0] r3_prod;
    hsla_pkg::t_side      r3_side;
    // stage 4
    logic [2:0]           r4_sext;
    logic [F:0]           r4_w;
    logic signed [SW-1:0] r4_c;
    logic signed [MW-1:0] r4_m;
    hsla_pkg::t_side      r4_side;
    // stage 5
    logic [2:0]           r5_sext;
    logic signed [SW-1:0] r5_c;
    logic signed [MW-1:0] r5_m;
    logic signed [PW-1:0] r5_prod;
    hsla_pkg::t_side      r5_side;
    // stage 6
    logic signed [VW-1:0] r6_vr, r6_vg, r6_vb;
    hsla_pkg::t_side      r6_side;
    // stage 7 (output)
    logic [7:0]           r7_red, r7_green, r7_blue, r7_alpha;

    // ---- stage 1: hue, offset lightness
    logic signed [HW-1:0] n_hue, base_v, mag_v, hue_raw;
    logic [2:0]           base_i;
    logic [F-1:0]         frac;

    always_comb begin
        case (i_side.base)
            hsla_pkg::BASE_RED:   base_i = 3'd0;
            hsla_pkg::BASE_GREEN: base_i = 3'd2;
            default:              base_i = 3'd4;
        endcase
        base_v  = HW'(base_i) << F;
        mag_v   = HW'(i_mag);
        hue_raw = i_side.num_neg ? base_v - mag_v : base_v + mag_v;
        n_hue   = hue_raw;
        if (hue_raw < 0) begin
            n_hue = hue_raw + SIXQ;
        end else if (hue_raw >= SIXQ) begin
            n_hue = hue_raw - SIXQ;
        end
        if (i_side.d_zero) begin
            n_hue = '0;
        end
        frac = n_hue[F-1:0];
    end

    // ---- stage 2: span
    logic signed [SW-1:0] t2, a2;
    always_comb begin
        t2 = (SW'(r1_lp) <<< 1) - QS;
        a2 = (t2 < 0) ? -t2 : t2;
    end

    // ---- stage 3: span * sat
    logic signed [F+1:0] sat_s;
    assign sat_s = $signed({1'b0, r2_sat});

    // ---- stage 4: chroma, m
    logic signed [SW-1:0] c4;
    assign c4 = SW'(r3_prod >>> F);

    // ---- stage 5: chroma * w
    logic signed [F+1:0] w_s;
    assign w_s = $signed({1'b0, r4_w});

    // ---- stage 6: components
    logic signed [SW-1:0] x6, cr, cg, cb;
    always_comb begin
        x6 = SW'(r5_prod >>> F);
        case (r5_sext)
            3'd0:    begin cr = r5_c; cg = x6;   cb = '0;   end
            3'd1:    begin cr = x6;   cg = r5_c; cb = '0;   end
            3'd2:    begin cr = '0;   cg = r5_c; cb = x6;   end
            3'd3:    begin cr = '0;   cg = x6;   cb = r5_c; end
            3'd4:    begin cr = x6;   cg = '0;   cb = r5_c; end
            default: begin cr = r5_c; cg = '0;   cb = x6;   end
        endcase
    end

    // ---- stage 7: scale to 0..255 and saturate
    function automatic logic [7:0] to_ch(input logic signed [VW-1:0] v);
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] q;
        t = (TW'(v) <<< 8) - TW'(v);
        q = t >>> F;
        if (q < 0) begin
            to_ch = 8'd0;
        end else if (q > TW'(255)) begin
            to_ch = 8'd255;
        end else begin
            to_ch = q[7:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sext <= n_hue[F+2:F];
            r1_w    <= n_hue[F] ? QU - {1'b0, frac} : {1'b0, frac};
            r1_lp   <= LW'($signed({1'b0, i_lum})) + LW'(i_delta);
            r1_sat  <= i_side.d_zero ? '0 : i_sat;
            r1_side <= i_side;

            r2_sext <= r1_sext;
            r2_w    <= r1_w;
            r2_lp   <= r1_lp;
            r2_sat  <= r1_sat;
            r2_span <= QS - a2;
            r2_side <= r1_side;

            r3_sext <= r2_sext;
            r3_w    <= r2_w;
            r3_lp   <= r2_lp;
            r3_prod <= r2_span * sat_s;
            r3_side <= r2_side;

            r4_sext <= r3_sext;
            r4_w    <= r3_w;
            r4_c    <= c4;
            r4_m    <= MW'(r3_lp) - MW'(c4 >>> 1);
            r4_side <= r3_side;

            r5_sext <= r4_sext;
            r5_c    <= r4_c;
            r5_m    <= r4_m;
            r5_prod <= r4_c * w_s;
            r5_side <= r4_side;

            r6_vr   <= VW'(cr) + VW'(r5_m);
            r6_vg   <= VW'(cg) + VW'(r5_m);
            r6_vb   <= VW'(cb) + VW'(r5_m);
            r6_side <= r5_side;

            r7_red   <= r6_side.mask ? to_ch(r6_vr) : 8'd0;
            r7_green <= r6_side.mask ? to_ch(r6_vg) : 8'd0;
            r7_blue  <= r6_side.mask ? to_ch(r6_vb) : 8'd0;
            r7_alpha <= r6_side.mask ? r6_side.alpha : 8'd0;
        end
    end

    assign o_valid = r_vld[6];
    assign o_red   = r7_red;
    assign o_green = r7_green;
    assign o_blue  = r7_blue;
    assign o_alpha = r7_alpha;
endmodule

// ----- sv/hsla_chk.sv -----
// ----------------------------------------------------------------------------
// HSL lightness adjust - port checker
// Flow control and register readback seen at the top-level ports.
// ----------------------------------------------------------------------------
module hsla_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [hsla_pkg::APB_AW-1:0]  paddr,
    input logic [hsla_pkg::APB_DW-1:0]  pwdata,
    input logic [hsla_pkg::APB_DW-1:0]  prdata
);
    // pipe is empty straight after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid after reset");

    // a draining output always lets a new pixel in
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    // offset reads back what was written
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == hsla_pkg::REG_LIGHTNESS_DELTA)
        |=> (paddr[2] != hsla_pkg::REG_LIGHTNESS_DELTA) ||
            (prdata[hsla_pkg::DELTA_W-1:0] == $past(pwdata[hsla_pkg::DELTA_W-1:0])))
        else $error("lightness offset readback mismatch");
endmodule

bind hsl_lightness_adjust_unit hsla_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_pix.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
